>>> sv/iira_pkg.sv
// Package for the indexed insert/remove array: build constants, codes and
// the command/status bundles between controller and datapath.
// No dependencies.
package iira_pkg;

    // Build-time geometry
    localparam int DEPTH     = 64;
    localparam int WORD_BITS = 32;
    localparam int ADDR_BITS = $clog2(DEPTH);
    localparam int CNT_BITS  = $clog2(DEPTH + 1);

    // Fixed field widths of the channels
    localparam int CMD_BITS    = 3;
    localparam int INDEX_BITS  = 7;
    localparam int VALUE_BITS  = 32;
    localparam int COUNT_BITS  = 7;
    localparam int STATUS_BITS = 2;

    // Width wide enough to compare an index against the fill count
    localparam int CMP_BITS = (CNT_BITS > INDEX_BITS) ? CNT_BITS : INDEX_BITS;

    // Request codes; 5 to 7 are ignored
    typedef enum logic [CMD_BITS-1:0] {
        CMD_APPEND    = 3'd0,
        CMD_INSERT    = 3'd1,
        CMD_REMOVE    = 3'd2,
        CMD_READ      = 3'd3,
        CMD_OVERWRITE = 3'd4
    } t_cmd;

    // Response status codes
    typedef enum logic [STATUS_BITS-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } t_status;

    // Controller states
    typedef enum logic [1:0] {
        FSM_IDLE,
        FSM_SHIFT,
        FSM_FILL,
        FSM_RESP
    } t_state;

    // Controller -> datapath
    typedef struct packed {
        logic take;     // accept the request beat and decode it
        logic step;     // move one element
        logic fill;     // write the inserted word into the gap
        logic respond;  // load the response register
    } t_dp_cmd;

    // Datapath -> controller
    typedef struct packed {
        logic need_shift;  // decoded request must move elements
        logic shift_last;  // current move is the final one
        logic is_insert;   // latched request is an insert
    } t_dp_stat;

endpackage

>>> sv/iira_if.sv
// Valid/ready channel interfaces for the request and response beats.
// Depends on iira_pkg.
interface iira_req_if;
    logic                                 valid;
    logic                                 ready;
    logic [iira_pkg::CMD_BITS-1:0]        cmd;
    logic [iira_pkg::INDEX_BITS-1:0]      index;
    logic signed [iira_pkg::VALUE_BITS-1:0] value;

    modport source (output valid, cmd, index, value, input ready);
    modport sink   (input valid, cmd, index, value, output ready);
endinterface

interface iira_rsp_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [iira_pkg::VALUE_BITS-1:0] read_value;
    logic [iira_pkg::COUNT_BITS-1:0]        fill_count;
    logic [iira_pkg::STATUS_BITS-1:0]       status;

    modport source (output valid, read_value, fill_count, status, input ready);
    modport sink   (input valid, read_value, fill_count, status, output ready);
endinterface

>>> sv/indexed_insert_remove_array_top.sv
// Ordered array of signed words with a fill count, capacity iira_pkg::DEPTH.
// Requests append, insert, remove, read or overwrite; each gives one response
// beat with the word read, the new fill count and a status. One request is
// worked on at a time and the request channel is ready only between requests.
// The elements sit in a RAM with one write and one read port, so elements
// move one at a time: an insert below the fill count moves each element from
// the index up and then fills the gap, a remove below the top moves each
// element above the index down, and other requests move nothing. A response
// held in the output register delays the next request only while it stalls.
// No clearing pass after reset: only positions below the fill count are read.
// Depends on iira_pkg, iira_if, iira_ram, iira_dp and iira_ctrl.
module indexed_insert_remove_array_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    iira_req_if.sink   i_req,
    iira_rsp_if.source o_rsp
);

    iira_pkg::t_dp_cmd  dp_cmd;
    iira_pkg::t_dp_stat dp_stat;
    logic               in_ready;
    logic               out_valid;

    iira_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .i_out_ready (o_rsp.ready),
        .i_stat      (dp_stat),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid),
        .o_cmd       (dp_cmd)
    );

    iira_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (dp_cmd),
        .i_req_cmd    (i_req.cmd),
        .i_req_index  (i_req.index),
        .i_req_value  (i_req.value),
        .o_stat       (dp_stat),
        .o_read_value (o_rsp.read_value),
        .o_fill_count (o_rsp.fill_count),
        .o_status     (o_rsp.status)
    );

    assign i_req.ready = in_ready;
    assign o_rsp.valid = out_valid;

endmodule

>>> sv/iira_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered
// read data. No dependencies.
module iira_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port, holds between reads
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> sv/iira_dp.sv
// Datapath: request decode, fill count, element store RAM with its shift
// pointer, and the response payload register.
// Depends on iira_pkg and iira_ram.
module iira_dp (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  iira_pkg::t_dp_cmd                      i_cmd,
    input  logic [iira_pkg::CMD_BITS-1:0]          i_req_cmd,
    input  logic [iira_pkg::INDEX_BITS-1:0]        i_req_index,
    input  logic signed [iira_pkg::VALUE_BITS-1:0] i_req_value,
    output iira_pkg::t_dp_stat                     o_stat,
    output logic signed [iira_pkg::VALUE_BITS-1:0] o_read_value,
    output logic [iira_pkg::COUNT_BITS-1:0]        o_fill_count,
    output logic [iira_pkg::STATUS_BITS-1:0]       o_status
);

    // Control state
    logic [iira_pkg::CNT_BITS-1:0]  r_count, n_count;

    // Latched request
    logic [iira_pkg::ADDR_BITS-1:0] r_src, n_src;
    logic [iira_pkg::ADDR_BITS-1:0] r_idx;
    logic [iira_pkg::WORD_BITS-1:0] r_word;
    iira_pkg::t_status              r_status;
    logic                           r_is_read;
    logic                           r_is_insert;

    // Response payload
    logic signed [iira_pkg::VALUE_BITS-1:0] r_read_value;
    logic [iira_pkg::COUNT_BITS-1:0]        r_fill_count;
    logic [iira_pkg::STATUS_BITS-1:0]       r_out_status;

    // Decode
    logic [iira_pkg::CMP_BITS-1:0]  idx_c, cnt_c, depth_c;
    logic [63:0]                    value_ext;
    logic [iira_pkg::WORD_BITS-1:0] in_word;
    logic [iira_pkg::ADDR_BITS-1:0] in_addr, cnt_addr, last_addr;
    iira_pkg::t_status              dec_status;
    logic                           dec_is_read;
    logic                           dec_shift;
    logic                           dec_wr, dec_rd;
    logic [iira_pkg::ADDR_BITS-1:0] dec_wr_addr, dec_rd_addr, dec_src;
    logic [iira_pkg::CNT_BITS-1:0]  dec_count;

    // RAM ports
    logic                           ram_wr_en, ram_rd_en;
    logic [iira_pkg::ADDR_BITS-1:0] ram_wr_addr, ram_rd_addr;
    logic [iira_pkg::WORD_BITS-1:0] ram_wr_data, ram_rd_data;
    logic [63:0]                    rd_ext;
    logic                           shift_last;

    assign idx_c     = iira_pkg::CMP_BITS'(i_req_index);
    assign cnt_c     = iira_pkg::CMP_BITS'(r_count);
    assign depth_c   = iira_pkg::CMP_BITS'(iira_pkg::DEPTH);
    assign value_ext = 64'(i_req_value);
    assign in_word   = value_ext[iira_pkg::WORD_BITS-1:0];
    assign in_addr   = iira_pkg::ADDR_BITS'(i_req_index);
    assign cnt_addr  = iira_pkg::ADDR_BITS'(r_count);
    assign last_addr = iira_pkg::ADDR_BITS'(r_count - 1'b1);

    // Decode the request against the current fill count
    always_comb begin
        dec_status  = iira_pkg::ST_OK;
        dec_is_read = 1'b0;
        dec_shift   = 1'b0;
        dec_wr      = 1'b0;
        dec_wr_addr = in_addr;
        dec_rd      = 1'b0;
        dec_rd_addr = in_addr;
        dec_src     = in_addr;
        dec_count   = r_count;
        case (i_req_cmd)
            iira_pkg::CMD_APPEND: begin
                if (cnt_c >= depth_c) begin
                    dec_status = iira_pkg::ST_FULL;
                end else begin
                    dec_wr      = 1'b1;
                    dec_wr_addr = cnt_addr;
                    dec_count   = r_count + 1'b1;
                end
            end
            iira_pkg::CMD_INSERT: begin
                if (idx_c > cnt_c) begin
                    dec_status = iira_pkg::ST_RANGE;
                end else if (cnt_c >= depth_c) begin
                    dec_status = iira_pkg::ST_FULL;
                end else if (idx_c == cnt_c) begin
                    // insert at the end: no move
                    dec_wr    = 1'b1;
                    dec_count = r_count + 1'b1;
                end else begin
                    // move top element first, count grows at the fill
                    dec_shift   = 1'b1;
                    dec_rd      = 1'b1;
                    dec_rd_addr = last_addr;
                    dec_src     = last_addr;
                end
            end
            iira_pkg::CMD_REMOVE: begin
                if (idx_c >= cnt_c) begin
                    dec_status = iira_pkg::ST_RANGE;
                end else if (idx_c == cnt_c - 1'b1) begin
                    dec_count = r_count - 1'b1;
                end else begin
                    dec_shift   = 1'b1;
                    dec_rd      = 1'b1;
                    dec_rd_addr = in_addr + 1'b1;
                    dec_src     = in_addr + 1'b1;
                end
            end
            iira_pkg::CMD_READ: begin
                if (idx_c >= cnt_c) begin
                    dec_status = iira_pkg::ST_RANGE;
                end else begin
                    dec_is_read = 1'b1;
                    dec_rd      = 1'b1;
                end
            end
            iira_pkg::CMD_OVERWRITE: begin
                if (idx_c >= cnt_c) begin
                    dec_status = iira_pkg::ST_RANGE;
                end else begin
                    dec_wr = 1'b1;
                end
            end
            default: begin
                // unknown code: ignored, status ok
            end
        endcase
    end

    // Final move: insert walks down to the target, remove up to the top
    assign shift_last = r_is_insert ? (r_src == r_idx) : (r_src == last_addr);

    // RAM port steering and next pointer/count
    always_comb begin
        ram_wr_en   = 1'b0;
        ram_wr_addr = dec_wr_addr;
        ram_wr_data = in_word;
        ram_rd_en   = 1'b0;
        ram_rd_addr = dec_rd_addr;
        n_src       = r_src;
        n_count     = r_count;
        if (i_cmd.take) begin
            ram_wr_en = dec_wr;
            ram_rd_en = dec_rd;
            n_src     = dec_src;
            n_count   = dec_count;
        end else if (i_cmd.step) begin
            ram_wr_en   = 1'b1;
            ram_wr_data = ram_rd_data;
            ram_wr_addr = r_is_insert ? r_src + 1'b1 : r_src - 1'b1;
            ram_rd_en   = !shift_last;
            ram_rd_addr = r_is_insert ? r_src - 1'b1 : r_src + 1'b1;
            n_src       = ram_rd_addr;
            if (shift_last && !r_is_insert) begin
                n_count = r_count - 1'b1;
            end
        end else if (i_cmd.fill) begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = r_idx;
            ram_wr_data = r_word;
            n_count     = r_count + 1'b1;
        end
    end

    iira_ram #(
        .WIDTH (iira_pkg::WORD_BITS),
        .DEPTH (iira_pkg::DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    // Fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    // Request latch and shift pointer
    always_ff @(posedge i_clk) begin
        r_src <= n_src;
        if (i_cmd.take) begin
            r_idx       <= in_addr;
            r_word      <= in_word;
            r_status    <= dec_status;
            r_is_read   <= dec_is_read;
            r_is_insert <= (i_req_cmd == iira_pkg::CMD_INSERT);
        end
    end

    // Response payload
    assign rd_ext = 64'(ram_rd_data);

    always_ff @(posedge i_clk) begin
        if (i_cmd.respond) begin
            r_read_value <= r_is_read ? rd_ext[iira_pkg::VALUE_BITS-1:0] : '0;
            r_fill_count <= iira_pkg::COUNT_BITS'(r_count);
            r_out_status <= r_status;
        end
    end

    assign o_stat.need_shift = dec_shift;
    assign o_stat.shift_last = shift_last;
    assign o_stat.is_insert  = r_is_insert;
    assign o_read_value      = r_read_value;
    assign o_fill_count      = r_fill_count;
    assign o_status          = r_out_status;

    // Checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= iira_pkg::CNT_BITS'(iira_pkg::DEPTH))
        else $error("fill count above capacity");

    a_count_moves_by_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(!i_rst_n) |-> (r_count == $past(r_count)) ||
        (r_count == $past(r_count) + 1'b1) || (r_count + 1'b1 == $past(r_count)))
        else $error("fill count jumped by more than one");

    a_one_command: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(i_cmd))
        else $error("several datapath commands at once");

endmodule

>>> sv/iira_ctrl.sv
// Controller: state machine that sequences decode, element moves, the
// insert fill and the response beat. Depends on iira_pkg.
module iira_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_out_ready,
    input  iira_pkg::t_dp_stat i_stat,
    output logic               o_in_ready,
    output logic               o_out_valid,
    output iira_pkg::t_dp_cmd  o_cmd
);

    iira_pkg::t_state r_state, n_state;
    logic             r_out_valid, n_out_valid;

    // State and response valid registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= iira_pkg::FSM_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Next state and commands
    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        case (r_state)
            iira_pkg::FSM_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.take = 1'b1;
                    n_state    = i_stat.need_shift ? iira_pkg::FSM_SHIFT
                                                   : iira_pkg::FSM_RESP;
                end
            end
            iira_pkg::FSM_SHIFT: begin
                o_cmd.step = 1'b1;
                if (i_stat.shift_last) begin
                    n_state = i_stat.is_insert ? iira_pkg::FSM_FILL
                                               : iira_pkg::FSM_RESP;
                end
            end
            iira_pkg::FSM_FILL: begin
                o_cmd.fill = 1'b1;
                n_state    = iira_pkg::FSM_RESP;
            end
            iira_pkg::FSM_RESP: begin
                // wait for the output register to free up
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.respond = 1'b1;
                    n_out_valid   = 1'b1;
                    n_state       = iira_pkg::FSM_IDLE;
                end
            end
            default: begin
                n_state = iira_pkg::FSM_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;

    // Checks
    a_insert_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == iira_pkg::FSM_SHIFT && i_stat.shift_last && i_stat.is_insert)
        |=> r_state == iira_pkg::FSM_FILL)
        else $error("insert finished moving without filling the gap");

    a_resp_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == iira_pkg::FSM_RESP && !r_out_valid) |=> r_out_valid)
        else $error("response not presented with free output register");

endmodule
